[rtl/py2rgb_pkg.sv]
`default_nettype none

package py2rgb_pkg;

  localparam int PIX_W  = 8;
  localparam int DIFF_W = 9;
  localparam int PROD_W = 25;
  localparam int TERM_W = 10;
  localparam int SUM_W  = 11;

  localparam int FRAC_BITS = 15;

  localparam logic signed [DIFF_W-1:0] CHROMA_OFFSET = 9'sd128;

  localparam logic signed [PROD_W-1:0] COEF_RV = 25'sd37221;
  localparam logic signed [PROD_W-1:0] COEF_GU = 25'sd12975;
  localparam logic signed [PROD_W-1:0] COEF_GV = 25'sd18949;
  localparam logic signed [PROD_W-1:0] COEF_BU = 25'sd66883;

  // byte_order register codes
  localparam logic ORDER_YUYV = 1'b0;
  localparam logic ORDER_UYVY = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] byte0;
    logic [PIX_W-1:0] byte1;
    logic [PIX_W-1:0] byte2;
    logic [PIX_W-1:0] byte3;
    logic             last_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] red_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] blue_second;
    logic             last_out;
  } out_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] r_term;
    logic signed [TERM_W-1:0] g_term;
    logic signed [TERM_W-1:0] b_term;
  } chroma_t;

endpackage

`default_nettype wire

[rtl/py2rgb_chroma.sv]
`default_nettype none

module py2rgb_chroma import py2rgb_pkg::*; (
  input  wire logic [PIX_W-1:0] u,
  input  wire logic [PIX_W-1:0] v,
  output chroma_t               terms
);

  logic signed [DIFF_W-1:0] du;
  logic signed [DIFF_W-1:0] dv;
  logic signed [PROD_W-1:0] du_x;
  logic signed [PROD_W-1:0] dv_x;
  logic signed [PROD_W-1:0] r_prod;
  logic signed [PROD_W-1:0] g_prod;
  logic signed [PROD_W-1:0] b_prod;
  logic signed [PROD_W-1:0] r_shr;
  logic signed [PROD_W-1:0] g_shr;
  logic signed [PROD_W-1:0] b_shr;

  assign du   = $signed({1'b0, u}) - CHROMA_OFFSET;
  assign dv   = $signed({1'b0, v}) - CHROMA_OFFSET;
  assign du_x = {{(PROD_W-DIFF_W){du[DIFF_W-1]}}, du};
  assign dv_x = {{(PROD_W-DIFF_W){dv[DIFF_W-1]}}, dv};

  // constant-coefficient products, shared by both pixels
  assign r_prod = dv_x * COEF_RV;
  assign g_prod = du_x * COEF_GU + dv_x * COEF_GV;
  assign b_prod = du_x * COEF_BU;

  // arithmetic shift rounds toward minus infinity
  assign r_shr = r_prod >>> FRAC_BITS;
  assign g_shr = g_prod >>> FRAC_BITS;
  assign b_shr = b_prod >>> FRAC_BITS;

  assign terms.r_term = r_shr[TERM_W-1:0];
  assign terms.g_term = g_shr[TERM_W-1:0];
  assign terms.b_term = b_shr[TERM_W-1:0];

endmodule

`default_nettype wire

[rtl/py2rgb_pixel.sv]
`default_nettype none

module py2rgb_pixel import py2rgb_pkg::*; (
  input  wire logic [PIX_W-1:0] luma,
  input  wire chroma_t          terms,
  output logic      [PIX_W-1:0] red,
  output logic      [PIX_W-1:0] green,
  output logic      [PIX_W-1:0] blue
);

  function automatic logic [PIX_W-1:0] clamp8(input logic signed [SUM_W-1:0] x);
    logic [PIX_W-1:0] res;
    if (x[SUM_W-1]) begin
      res = '0;
    end else if (x[SUM_W-2:PIX_W] != '0) begin
      res = '1;
    end else begin
      res = x[PIX_W-1:0];
    end
    return res;
  endfunction

  logic signed [SUM_W-1:0] y_x;
  logic signed [SUM_W-1:0] r_sum;
  logic signed [SUM_W-1:0] g_sum;
  logic signed [SUM_W-1:0] b_sum;

  assign y_x   = $signed({{(SUM_W-PIX_W){1'b0}}, luma});
  assign r_sum = y_x + {{(SUM_W-TERM_W){terms.r_term[TERM_W-1]}}, terms.r_term};
  assign g_sum = y_x - {{(SUM_W-TERM_W){terms.g_term[TERM_W-1]}}, terms.g_term};
  assign b_sum = y_x + {{(SUM_W-TERM_W){terms.b_term[TERM_W-1]}}, terms.b_term};

  assign red   = clamp8(r_sum);
  assign green = clamp8(g_sum);
  assign blue  = clamp8(b_sum);

endmodule

`default_nettype wire

[rtl/packed_yuv422_to_rgb.sv]
// channel   ports                              width   handshake
// input     start, busy, in_data (in_t)        33      start & !busy
// result    out_valid, out_data (out_t)        49      one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_data     1       cfg_valid & cfg_ready
//
// one request per clock; the result passes an input register,
// constant-coefficient color math and a result register
// busy and cfg_ready are held at their open values, nothing stalls the flow
// synchronous reset clears the valid flags and byte_order (YUYV)

`default_nettype none

module packed_yuv422_to_rgb import py2rgb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,

  output logic      out_valid,
  output out_t      out_data,

  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);

  logic in_vld_r;
  in_t  in_r;
  logic byte_order_r;
  logic out_vld_r;
  out_t out_r;
  out_t out_nxt;

  logic [PIX_W-1:0] y0;
  logic [PIX_W-1:0] y1;
  logic [PIX_W-1:0] u;
  logic [PIX_W-1:0] v;
  chroma_t          terms;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      byte_order_r <= ORDER_YUYV;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
      if (cfg_valid && cfg_ready) begin
        byte_order_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    if (in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    case (byte_order_r)
      ORDER_UYVY: begin
        u  = in_r.byte0;
        y0 = in_r.byte1;
        v  = in_r.byte2;
        y1 = in_r.byte3;
      end
      default: begin
        y0 = in_r.byte0;
        u  = in_r.byte1;
        y1 = in_r.byte2;
        v  = in_r.byte3;
      end
    endcase
  end

  py2rgb_chroma u_chroma (
    .u     (u),
    .v     (v),
    .terms (terms)
  );

  py2rgb_pixel u_pix_first (
    .luma  (y0),
    .terms (terms),
    .red   (out_nxt.red_first),
    .green (out_nxt.green_first),
    .blue  (out_nxt.blue_first)
  );

  py2rgb_pixel u_pix_second (
    .luma  (y1),
    .terms (terms),
    .red   (out_nxt.red_second),
    .green (out_nxt.green_second),
    .blue  (out_nxt.blue_second)
  );

  assign out_nxt.last_out = in_r.last_in;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[rtl/py2rgb_chk.sv]
`default_nettype none

module py2rgb_chk import py2rgb_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire in_t  in_data,
  input wire logic out_valid,
  input wire out_t out_data
);

  // every accepted request gives a result after the input and result registers
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted request produced no result");

  // no result without an earlier accepted request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // frame end flag travels with its macropixel
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_out == $past(in_data.last_in, 2)))
    else $error("last flag does not match its request");

  // neutral gray in every byte comes out as gray in both pixels, either byte order
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.byte0 == 8'd128 && in_data.byte1 == 8'd128 &&
     in_data.byte2 == 8'd128 && in_data.byte3 == 8'd128) |-> ##2
    (out_data.red_first == 8'd128 && out_data.green_first == 8'd128 &&
     out_data.blue_first == 8'd128 && out_data.red_second == 8'd128 &&
     out_data.green_second == 8'd128 && out_data.blue_second == 8'd128))
    else $error("gray request did not come out gray");

endmodule

bind packed_yuv422_to_rgb py2rgb_chk u_py2rgb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
  import py2rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 930;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic order;
    in_t  px;
    bit   known;
    out_t rgb;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  out_t pending_rgb[$];
  logic byte_order_model = ORDER_YUYV;
  int   mismatch_count = 0;
  int   quiet_cycles = 0;

  // gray rows (u = v = 128) give r = g = b = luma, so their results are typed in
  stim_row_t directed_rows [16] = '{
    '{ORDER_YUYV, '{8'd0, 8'd128, 8'd0, 8'd128, 1'b0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{ORDER_YUYV, '{8'd255, 8'd128, 8'd255, 8'd128, 1'b1}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
    '{ORDER_YUYV, '{8'd128, 8'd128, 8'd128, 8'd128, 1'b0}, 1'b1,
      '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b0}},
    '{ORDER_YUYV, '{8'd16, 8'd128, 8'd235, 8'd128, 1'b0}, 1'b1,
      '{8'd16, 8'd16, 8'd16, 8'd235, 8'd235, 8'd235, 1'b0}},
    '{ORDER_YUYV, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{ORDER_YUYV, '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{ORDER_YUYV, '{8'd255, 8'd0, 8'd0, 8'd255, 1'b0}, 1'b0, '0},
    '{ORDER_YUYV, '{8'd0, 8'd255, 8'd255, 8'd0, 1'b1}, 1'b0, '0},
    '{ORDER_YUYV, '{8'd76, 8'd84, 8'd149, 8'd255, 1'b0}, 1'b0, '0},
    '{ORDER_UYVY, '{8'd128, 8'd0, 8'd128, 8'd255, 1'b0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0}},
    '{ORDER_UYVY, '{8'd128, 8'd128, 8'd128, 8'd128, 1'b1}, 1'b1,
      '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1}},
    '{ORDER_UYVY, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{ORDER_UYVY, '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{ORDER_UYVY, '{8'd0, 8'd255, 8'd255, 8'd0, 1'b1}, 1'b0, '0},
    '{ORDER_UYVY, '{8'd255, 8'd0, 8'd0, 8'd255, 1'b0}, 1'b0, '0},
    '{ORDER_YUYV, '{8'd42, 8'd200, 8'd17, 8'd60, 1'b1}, 1'b0, '0}
  };

  packed_yuv422_to_rgb DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] saturate8(input int value);
    if (value < 0) return 8'd0;
    if (value > 255) return 8'd255;
    return value[7:0];
  endfunction

  // >>> on a signed int rounds toward minus infinity
  function automatic logic [23:0] luma_chroma_to_rgb(input int luma, input int du, input int dv);
    int red, green, blue;
    red   = luma + ((dv * int'(COEF_RV)) >>> FRAC_BITS);
    green = luma - ((du * int'(COEF_GU) + dv * int'(COEF_GV)) >>> FRAC_BITS);
    blue  = luma + ((du * int'(COEF_BU)) >>> FRAC_BITS);
    return {saturate8(red), saturate8(green), saturate8(blue)};
  endfunction

  function automatic out_t predict_rgb_pair(input in_t px, input logic order);
    int   y0, y1, du, dv;
    out_t rgb;
    if (order == ORDER_UYVY) begin
      du = int'(px.byte0); y0 = int'(px.byte1); dv = int'(px.byte2); y1 = int'(px.byte3);
    end else begin
      y0 = int'(px.byte0); du = int'(px.byte1); y1 = int'(px.byte2); dv = int'(px.byte3);
    end
    du = du - 128;
    dv = dv - 128;
    {rgb.red_first, rgb.green_first, rgb.blue_first} = luma_chroma_to_rgb(y0, du, dv);
    {rgb.red_second, rgb.green_second, rgb.blue_second} = luma_chroma_to_rgb(y1, du, dv);
    rgb.last_out = px.last_in;
    return rgb;
  endfunction

  function automatic logic [7:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int idle_gap(input bit no_idle);
    if (no_idle || $urandom_range(0, 99) >= 15) return 0;
    return $urandom_range(1, 4);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_channel(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // start stays high on return so back-to-back requests keep it raised
  task automatic send_macropixel(input in_t px, input bit known, input out_t known_rgb);
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
    pending_rgb.push_back(known ? known_rgb : predict_rgb_pair(px, byte_order_model));
  endtask

  task automatic write_byte_order(input logic order);
    start <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_data  <= order;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    byte_order_model = order;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_rgb.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", out_data));
      end else begin
        want = pending_rgb.pop_front();
        check_channel("red_first", out_data.red_first, want.red_first);
        check_channel("green_first", out_data.green_first, want.green_first);
        check_channel("blue_first", out_data.blue_first, want.blue_first);
        check_channel("red_second", out_data.red_second, want.red_second);
        check_channel("green_second", out_data.green_second, want.green_second);
        check_channel("blue_second", out_data.blue_second, want.blue_second);
        check_channel("last_out", 8'(out_data.last_out), 8'(want.last_out));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("packed_yuv422_to_rgb regression: fail");
      $finish;
    end
  end

  initial begin
    in_t px;
    int  sent;
    int  phase_len;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first rows run on the reset byte order
    foreach (directed_rows[i]) begin
      if (directed_rows[i].order != byte_order_model)
        write_byte_order(directed_rows[i].order);
      pause_input(idle_gap(1'b0));
      send_macropixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].rgb);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 160);
      write_byte_order(logic'($urandom_range(0, 1)));
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        px.byte0   = random_sample();
        px.byte1   = random_sample();
        px.byte2   = random_sample();
        px.byte3   = random_sample();
        px.last_in = ($urandom_range(0, 7) == 0);
        // back-to-back stretch in the middle of the run
        pause_input(idle_gap(sent >= 300 && sent < 550));
        send_macropixel(px, 1'b0, '0);
        sent++;
      end
    end

    start <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("packed_yuv422_to_rgb regression: pass");
    else
      $display("packed_yuv422_to_rgb regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

[packed_yuv422_to_rgb.f]
rtl/py2rgb_pkg.sv
rtl/py2rgb_chroma.sv
rtl/py2rgb_pixel.sv
rtl/packed_yuv422_to_rgb.sv
rtl/py2rgb_chk.sv
verif/testbench.sv
